FILE: rtl/fwe_pkg.sv
// ----------------------------------------------------------------------------
// Falloff weight evaluator package
// Shared fixed point constants, register and curve codes, and the side-band
// structures that travel with an item through the divider and curve units.
// ----------------------------------------------------------------------------
package fwe_pkg;

	localparam int FRAC_BITS          = 16;
	localparam int UNIT               = 1 << FRAC_BITS;
	localparam int DEFAULT_MAX_POINTS = 256;
	localparam int DIV_BITS_PER_STAGE = 2;

	typedef enum logic [2:0] {
		PROF_LINEAR   = 3'd0,
		PROF_SMOOTH   = 3'd1,
		PROF_EASE_IN  = 3'd2,
		PROF_EASE_OUT = 3'd3,
		PROF_CONST    = 3'd4
	} profile_t;

	typedef enum logic [2:0] {
		REG_BAND_START = 3'd0,
		REG_BAND_END   = 3'd1,
		REG_INVERT     = 3'd2,
		REG_STRENGTH   = 3'd3,
		REG_PROFILE    = 3'd4,
		REG_POINTS     = 3'd5
	} reg_idx_t;

	// Band position decided without the divider.
	typedef struct packed {
		logic force_u;
		logic force_one;
	} band_side_t;

	// Data that rides along with the table lookup.
	typedef struct packed {
		logic               ident;
		logic signed [19:0] r;
		logic [16:0]        t;
	} interp_side_t;

	typedef struct packed {
		interp_side_t isd;
		logic         one1;
	} table_side_t;

endpackage

FILE: rtl/falloff_weight_evaluator_top.sv
// ----------------------------------------------------------------------------
// Falloff weight evaluator
// Throughput: one item per cycle unless out_ready stalls the output; the
// two 8-stage dividers, two bits a stage, and the curve multipliers are
// fully pipelined.
// Reset: arst_n clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module falloff_weight_evaluator_top #(
	parameter int MAX_TABLE_POINTS = fwe_pkg::DEFAULT_MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] distance,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [24:0] weight
);
	import fwe_pkg::*;

	// Width of a table index and of the saturated point count.
	localparam int DW = ($clog2(MAX_TABLE_POINTS) < 1) ? 1 : $clog2(MAX_TABLE_POINTS);
	localparam int NW = $clog2(MAX_TABLE_POINTS + 1);
	localparam int CW = (NW > 9) ? NW : 9;

	// Configuration registers, read directly by every stage. The user must
	// change them only while the pipeline is empty; the block does not check.
	logic signed [31:0] band_start_q, band_end_q;
	logic [16:0]        invert_q;
	logic signed [24:0] strength_q;
	logic [2:0]         curve_profile_q;
	logic [8:0]         table_points_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_start_q    <= '0;
			band_end_q      <= 32'sd65536;
			invert_q        <= '0;
			strength_q      <= 25'sd65536;
			curve_profile_q <= PROF_LINEAR;
			table_points_q  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_BAND_START: band_start_q    <= pwdata;
				REG_BAND_END:   band_end_q      <= pwdata;
				REG_INVERT:     invert_q        <= pwdata[16:0];
				REG_STRENGTH:   strength_q      <= pwdata[24:0];
				REG_PROFILE:    curve_profile_q <= pwdata[2:0];
				REG_POINTS:     table_points_q  <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_BAND_START: prdata = band_start_q;
			REG_BAND_END:   prdata = band_end_q;
			REG_INVERT:     prdata = {15'd0, invert_q};
			REG_STRENGTH:   prdata = {{7{strength_q[24]}}, strength_q};
			REG_PROFILE:    prdata = {29'd0, curve_profile_q};
			REG_POINTS:     prdata = {23'd0, table_points_q};
			default:        prdata = '0;
		endcase
	end

	// The whole pipeline advances together; the last stage is the output
	// register, so a new item enters whenever the result there is taken or
	// there is none.
	logic en;
	logic vld_s1, vld_s3, vld_s4, vld_s5, vld_s7, vld_s8, vld_s9, vld_s10;

	assign en       = !vld_s10 || out_ready;
	assign in_ready = en;

	// Stage 1: offset into the band and the band span, both 33 bits.
	logic signed [32:0] diff_s1, span_s1;

	// Band position. A zero-width band, a zero offset, opposite signs or a
	// distance beyond the span settle the clamped position without dividing;
	// otherwise the divider yields the 16 fraction bits of |diff| / |span|.
	logic [32:0]  diff_neg, span_neg;
	logic [31:0]  a_mag, b_mag;
	band_side_t   bside, bside_d;
	logic         bvld_d;
	logic [0:0][31:0] bnum;
	logic [0:0][15:0] bquo;

	always_comb begin
		diff_neg = -diff_s1;
		span_neg = -span_s1;
		a_mag    = diff_s1[32] ? diff_neg[31:0] : diff_s1[31:0];
		b_mag    = span_s1[32] ? span_neg[31:0] : span_s1[31:0];
		bside.force_u   = 1'b1;
		bside.force_one = 1'b0;
		if (span_s1 == '0) begin
			bside.force_one = !diff_s1[32];
		end else if ((diff_s1[32] != span_s1[32]) || (diff_s1 == '0)) begin
			bside.force_one = 1'b0;
		end else if (a_mag >= b_mag) begin
			bside.force_one = 1'b1;
		end else begin
			bside.force_u = 1'b0;
		end
		bnum[0] = a_mag;
	end

	fwe_div #(
		.LANES(1), .DW(32), .QB(FRAC_BITS), .BPS(DIV_BITS_PER_STAGE),
		.TW($bits(band_side_t))
	) u_band_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1),
		.num(bnum), .dvs(b_mag), .tag_in(bside),
		.out_vld(bvld_d), .quo(bquo), .tag_out(bside_d)
	);

	// Stage 3: blend toward the inverse, (ONE - 2u) * invert.
	logic [16:0]        u_nx, u_s3;
	logic signed [17:0] m_nx;
	logic signed [35:0] inv_s3;

	assign u_nx = bside_d.force_u ? (bside_d.force_one ? 17'(UNIT) : 17'd0)
		: {1'b0, bquo[0]};
	assign m_nx = 18'(UNIT) - $signed({u_nx, 1'b0});

	// Stage 4: r = ONE - (u + blend / ONE), the division truncating toward zero.
	logic signed [35:0] inv_adj;
	logic signed [19:0] r_nx, r_s4;

	assign inv_adj = inv_s3 + (inv_s3[35] ? 36'(UNIT - 1) : 36'sd0);
	assign r_nx    = 20'(UNIT) - ($signed({3'b0, u_s3}) + inv_adj[FRAC_BITS+19:FRAC_BITS]);

	// Stage 5: scale the clamped position by the table's interval count.
	logic [CW-1:0]      tp_ext;
	logic [NW-1:0]      nsat;
	logic [DW-1:0]      nm1;
	logic               ident_nx, ident_s5;
	logic [16:0]        rc;
	logic [16+DW:0]     x_s5;
	logic signed [19:0] r_s5;

	assign tp_ext   = CW'(table_points_q);
	assign nsat     = (tp_ext > CW'(MAX_TABLE_POINTS)) ? NW'(MAX_TABLE_POINTS) : NW'(tp_ext);
	assign ident_nx = nsat < NW'(2);
	assign nm1      = DW'(nsat - NW'(1));
	assign rc       = r_s4[19] ? 17'd0 : ((r_s4 > 20'(UNIT)) ? 17'(UNIT) : r_s4[16:0]);

	// Table index and interpolation fraction. The last interval is used
	// when the position lands exactly on the final point.
	logic [DW-1:0]        ix, k0, k1;
	logic                 last_pt;
	logic [16:0]          t_nx;
	logic [1:0][DW-1:0]   tnum;
	table_side_t          tside, tside_d;
	logic                 tvld_d;
	logic [1:0][15:0]     tquo;

	always_comb begin
		ix      = x_s5[FRAC_BITS+DW-1:FRAC_BITS];
		last_pt = (ix == nm1);
		k0      = last_pt ? (nm1 - DW'(1)) : ix;
		k1      = k0 + DW'(1);
		t_nx    = last_pt ? 17'(UNIT) : {1'b0, x_s5[FRAC_BITS-1:0]};
		tnum[0] = k0;
		tnum[1] = k1;
		tside.isd.ident = ident_s5;
		tside.isd.r     = r_s5;
		tside.isd.t     = t_nx;
		tside.one1      = (k1 == nm1);
	end

	// Table positions p = k * ONE / (n - 1), both points of the interval.
	fwe_div #(
		.LANES(2), .DW(DW), .QB(FRAC_BITS), .BPS(DIV_BITS_PER_STAGE),
		.TW($bits(table_side_t))
	) u_table_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s5),
		.num(tnum), .dvs(nm1), .tag_in(tside),
		.out_vld(tvld_d), .quo(tquo), .tag_out(tside_d)
	);

	logic [1:0][16:0] pp, ee;
	interp_side_t     cside;
	logic             cvld;

	assign pp[0] = {1'b0, tquo[0]};
	assign pp[1] = tside_d.one1 ? 17'(UNIT) : {1'b0, tquo[1]};

	fwe_curve u_curve (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(tvld_d),
		.p(pp), .profile(profile_t'(curve_profile_q)), .side_in(tside_d.isd),
		.out_vld(cvld), .e(ee), .side_out(cside)
	);

	// Stage 7: (e1 - e0) * t.
	logic signed [17:0] dif;
	logic signed [35:0] ip_s7;
	logic [16:0]        e0_s7;
	logic signed [19:0] r_s7;
	logic               ident_s7;

	assign dif = $signed({1'b0, ee[1]}) - $signed({1'b0, ee[0]});

	// Stage 8: interpolated sample, or the unclamped r for a short table.
	logic signed [35:0] ip_adj;
	logic signed [19:0] w_nx, w_s8;

	assign ip_adj = ip_s7 + (ip_s7[35] ? 36'(UNIT - 1) : 36'sd0);
	assign w_nx   = ident_s7 ? r_s7
		: ($signed({3'b0, e0_s7}) + ip_adj[FRAC_BITS+19:FRAC_BITS]);

	// Stage 9 multiplies by strength; stage 10 truncates and wraps to 25 bits.
	logic signed [44:0] wp_s9, wp_adj;
	logic signed [24:0] weight_s10;

	assign wp_adj = wp_s9 + (wp_s9[44] ? 45'(UNIT - 1) : 45'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s3  <= bvld_d;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s7  <= cvld;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1    <= $signed({distance[31], distance})
				- $signed({band_start_q[31], band_start_q});
			span_s1    <= $signed({band_end_q[31], band_end_q})
				- $signed({band_start_q[31], band_start_q});
			u_s3       <= u_nx;
			inv_s3     <= m_nx * $signed({1'b0, invert_q});
			r_s4       <= r_nx;
			r_s5       <= r_s4;
			ident_s5   <= ident_nx;
			x_s5       <= (17+DW)'(rc) * (17+DW)'(nm1);
			ip_s7      <= dif * $signed({1'b0, cside.t});
			e0_s7      <= ee[0];
			r_s7       <= cside.r;
			ident_s7   <= cside.ident;
			w_s8       <= w_nx;
			wp_s9      <= w_s8 * strength_q;
			weight_s10 <= wp_adj[FRAC_BITS+24:FRAC_BITS];
		end
	end

	assign out_valid = vld_s10;
	assign weight    = weight_s10;

endmodule

FILE: rtl/fwe_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces QB fraction bits of num/dvs (num below dvs) for several lanes that
// share one divisor, BPS quotient bits per register stage.
// ----------------------------------------------------------------------------
module fwe_div #(
	parameter int LANES = 1,
	parameter int DW    = 8,
	parameter int QB    = 16,
	parameter int BPS   = 2,
	parameter int TW    = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [LANES-1:0][DW-1:0]   num,
	input  logic [DW-1:0]              dvs,
	input  logic [TW-1:0]              tag_in,
	output logic                       out_vld,
	output logic [LANES-1:0][QB-1:0]   quo,
	output logic [TW-1:0]              tag_out
);

	localparam int STG = (QB + BPS - 1) / BPS;

	logic [STG-1:0]                vld_s;
	logic [LANES-1:0][DW-1:0]      rem_s  [STG];
	logic [LANES-1:0][QB-1:0]      quo_s  [STG];
	logic [DW-1:0]                 dvs_s  [STG];
	logic [TW-1:0]                 tag_s  [STG];
	logic [LANES-1:0][DW-1:0]      rem_nx [STG];
	logic [LANES-1:0][QB-1:0]      quo_nx [STG];

	function automatic logic [DW+QB-1:0] div_step(input logic [DW-1:0] rem,
			input logic [QB-1:0] q_in, input logic [DW-1:0] d, input int base);
		logic [DW:0]   sh;
		logic [DW-1:0] r;
		logic [QB-1:0] q;
		r = rem;
		q = q_in;
		for (int b = 0; b < BPS; b++) begin
			if (base + b < QB) begin
				sh = {r, 1'b0};
				if (sh >= {1'b0, d}) begin
					sh = sh - {1'b0, d};
					q  = {q[QB-2:0], 1'b1};
				end else begin
					q  = {q[QB-2:0], 1'b0};
				end
				r = sh[DW-1:0];
			end
		end
		return {r, q};
	endfunction

	always_comb begin
		for (int j = 0; j < STG; j++) begin
			for (int l = 0; l < LANES; l++) begin
				if (j == 0) begin
					{rem_nx[j][l], quo_nx[j][l]} = div_step(num[l], '0, dvs, 0);
				end else begin
					{rem_nx[j][l], quo_nx[j][l]} = div_step(rem_s[(j == 0) ? 0 : j-1][l],
						quo_s[(j == 0) ? 0 : j-1][l], dvs_s[(j == 0) ? 0 : j-1], j*BPS);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			for (int j = 0; j < STG; j++) begin
				vld_s[j] <= (j == 0) ? in_vld : vld_s[(j == 0) ? 0 : j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < STG; j++) begin
				rem_s[j] <= rem_nx[j];
				quo_s[j] <= quo_nx[j];
				dvs_s[j] <= (j == 0) ? dvs : dvs_s[(j == 0) ? 0 : j-1];
				tag_s[j] <= (j == 0) ? tag_in : tag_s[(j == 0) ? 0 : j-1];
			end
		end
	end

	assign out_vld = vld_s[STG-1];
	assign quo     = quo_s[STG-1];
	assign tag_out = tag_s[STG-1];

endmodule

FILE: rtl/fwe_curve.sv
// ----------------------------------------------------------------------------
// Falloff curve unit
// Turns two table positions into curve values in three register stages:
// squares, the smoothstep product, then the profile select.
// ----------------------------------------------------------------------------
module fwe_curve (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [1:0][16:0]      p,
	input  fwe_pkg::profile_t     profile,
	input  fwe_pkg::interp_side_t side_in,
	output logic                  out_vld,
	output logic [1:0][16:0]      e,
	output fwe_pkg::interp_side_t side_out
);
	import fwe_pkg::*;

	logic                  vld_s1, vld_s2, vld_s3;
	logic [1:0][16:0]      p_s1, p_s2;
	logic [1:0][33:0]      sq_s1, cq_s1;
	logic [1:0][16:0]      q_s2, cq_s2;
	logic [1:0][34:0]      sm_s2;
	logic [1:0][16:0]      e_s3;
	interp_side_t          side_s1, side_s2, side_s3;
	logic [1:0][16:0]      cm;
	logic [1:0][16:0]      e_nx;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			cm[l] = 17'(UNIT) - p[l];
			unique case (profile)
				PROF_LINEAR:   e_nx[l] = p_s2[l];
				PROF_SMOOTH:   e_nx[l] = sm_s2[l][FRAC_BITS+16:FRAC_BITS];
				PROF_EASE_IN:  e_nx[l] = q_s2[l];
				PROF_EASE_OUT: e_nx[l] = 17'(UNIT) - cq_s2[l];
				PROF_CONST:    e_nx[l] = (p_s2[l] != '0) ? 17'(UNIT) : '0;
				default:       e_nx[l] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				p_s1[l]  <= p[l];
				sq_s1[l] <= 34'(p[l]) * 34'(p[l]);
				cq_s1[l] <= 34'(cm[l]) * 34'(cm[l]);
				p_s2[l]  <= p_s1[l];
				q_s2[l]  <= sq_s1[l][FRAC_BITS+16:FRAC_BITS];
				cq_s2[l] <= cq_s1[l][FRAC_BITS+16:FRAC_BITS];
				sm_s2[l] <= 35'(sq_s1[l][FRAC_BITS+16:FRAC_BITS])
					* 35'(18'(3*UNIT) - {p_s1[l], 1'b0});
				e_s3[l]  <= e_nx[l];
			end
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
		end
	end

	assign out_vld  = vld_s3;
	assign e        = e_s3;
	assign side_out = side_s3;

endmodule
